@@ rtl/rtp_fragment_reassembly_tracker_top_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the RTP fragment reassembly tracker.
// Both macros sample on the rising edge of clk and stay quiet during reset.
// ---------------------------------------------------------------------------
`ifndef RTP_FRAGMENT_REASSEMBLY_TRACKER_TOP_ASSERT_SVH
`define RTP_FRAGMENT_REASSEMBLY_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication: antecedent holds, consequent holds in that cycle.
`define RTP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: antecedent holds, consequent holds in the next cycle.
`define RTP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/rtpfrt_pkg.sv @@
// ---------------------------------------------------------------------------
// rtpfrt_pkg
// Types and constants of the RTP fragment reassembly tracker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtpfrt_pkg;

	localparam int TS_W    = 32;
	localparam int SEQ_W   = 16;
	localparam int LEN_W   = 11;
	localparam int CNT_W   = 17;
	localparam int BYTES_W = 27;
	localparam int SLOT_OUT_W = 3;

	localparam int DEFAULT_SLOTS = 8;

	// Payload length above this counts as this many bytes
	localparam int MAX_FRAGMENT_BYTES = 1500;

	localparam logic [SEQ_W-1:0]   SEQ_MASK  = 16'hffff;
	localparam logic [CNT_W-1:0]   COUNT_MAX = 17'h10000;
	localparam logic [BYTES_W-1:0] BYTES_MAX = 27'h7ffffff;

	// Register index, taken from paddr bit 2
	localparam logic REG_FRAGMENT_MODE = 1'b0;

	typedef enum logic [2:0] {
		DISP_PASS     = 3'd0,
		DISP_OPEN     = 3'd1,
		DISP_STORED   = 3'd2,
		DISP_COMPLETE = 3'd3,
		DISP_DROP     = 3'd4
	} disp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} state_t;

	// Per-slot record held in the slot memory
	typedef struct packed {
		logic [SEQ_W-1:0]   start_seq;
		logic [SEQ_W-1:0]   end_seq;
		logic               end_known;
		logic [CNT_W-1:0]   count;
		logic [BYTES_W-1:0] bytes;
	} slot_entry_t;

endpackage

@@ rtl/rtp_fragment_reassembly_tracker_top.sv @@
// ---------------------------------------------------------------------------
// rtp_fragment_reassembly_tracker_top
// Tracks marker-delimited RTP frames by timestamp and reports one result word
// per packet header word.
// ---------------------------------------------------------------------------
// Each packet header goes through IDLE (accept), LOOKUP (timestamp match
// against the slot tags with a read of the matching slot record) and UPDATE
// (the read-modify-write of that record and the load of the result register).
// A header is accepted only when the previous one has finished; the update
// waits while the result register still holds a word that was not taken. Slot
// valid bits are flip-flops cleared by reset, so no clearing pass runs. The
// user is to write fragment_mode (APB byte address 0) only while the block is
// idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtp_fragment_reassembly_tracker_top #(
	parameter int SLOTS = rtpfrt_pkg::DEFAULT_SLOTS
) (
	input  logic         clk,
	input  logic         arst_n,
	// APB configuration port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// Header stream in
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tdata: timestamp[31:0], seq_number[47:32], pkt_len[58:48], zero fill
	input  logic [63:0]  s_tdata,
	// s_tuser: marker
	input  logic         s_tuser,
	// Result stream out
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata: slot_index[2:0], frame_timestamp[34:3], start_seq[50:35],
	//          fragment_count[67:51], total_bytes[94:68], zero fill
	output logic [95:0]  m_tdata,
	// m_tuser: disposition
	output logic [2:0]   m_tuser
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int TS_W    = rtpfrt_pkg::TS_W;
	localparam int SEQ_W   = rtpfrt_pkg::SEQ_W;
	localparam int LEN_W   = rtpfrt_pkg::LEN_W;
	localparam int CNT_W   = rtpfrt_pkg::CNT_W;
	localparam int BYTES_W = rtpfrt_pkg::BYTES_W;

	// Control
	rtpfrt_pkg::state_t state_q, state_n;
	logic lookup_en;
	logic update_go;
	logic mode_q;

	// Captured header
	logic [TS_W-1:0]  ts_s1;
	logic [SEQ_W-1:0] seq_s1;
	logic             mark_s1;
	logic [LEN_W-1:0] len_s1;
	logic [LEN_W-1:0] len_clamped;

	// Tag match results
	logic              hit;
	logic              free;
	logic [SLOT_W-1:0] hit_idx;
	logic [SLOT_W-1:0] free_idx;
	logic              hit_s2;
	logic              free_s2;
	logic [SLOT_W-1:0] hit_idx_s2;
	logic [SLOT_W-1:0] free_idx_s2;

	// Slot tags in flops, slot records in memory
	logic [SLOTS-1:0]  slot_valid_q;
	logic [TS_W-1:0]   slot_ts_q [SLOTS];
	rtpfrt_pkg::slot_entry_t slot_mem [SLOTS];
	rtpfrt_pkg::slot_entry_t slot_rd_q;

	// Update results
	rtpfrt_pkg::disp_t       disp_n;
	logic [SLOT_W-1:0]       idx_n;
	rtpfrt_pkg::slot_entry_t entry_n;
	logic                    mem_we;
	logic [CNT_W-1:0]        cnt_inc;
	logic [BYTES_W:0]        bytes_sum;
	logic [BYTES_W-1:0]      bytes_new;
	logic [SEQ_W-1:0]        end_new;
	logic                    known_new;
	logic [CNT_W-1:0]        expect_cnt;
	logic                    complete;
	logic [SEQ_W-1:0]        out_seq_n;
	logic [CNT_W-1:0]        out_cnt_n;
	logic [BYTES_W-1:0]      out_bytes_n;

	// Result register
	logic                    m_tvalid_q;
	rtpfrt_pkg::disp_t       out_disp_q;
	logic [2:0]              out_slot_q;
	logic [TS_W-1:0]         out_ts_q;
	logic [SEQ_W-1:0]        out_seq_q;
	logic [CNT_W-1:0]        out_cnt_q;
	logic [BYTES_W-1:0]      out_bytes_q;

	// APB: always ready, one register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == rtpfrt_pkg::REG_FRAGMENT_MODE) ? {31'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready &&
				(paddr[2] == rtpfrt_pkg::REG_FRAGMENT_MODE)) begin
			mode_q <= pwdata[0];
		end
	end

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			rtpfrt_pkg::ST_IDLE: begin
				if (s_tvalid) state_n = rtpfrt_pkg::ST_LOOKUP;
			end
			rtpfrt_pkg::ST_LOOKUP: begin
				state_n = rtpfrt_pkg::ST_UPDATE;
			end
			rtpfrt_pkg::ST_UPDATE: begin
				if (!m_tvalid_q || m_tready) state_n = rtpfrt_pkg::ST_IDLE;
			end
			default: begin
				state_n = rtpfrt_pkg::ST_IDLE;
			end
		endcase
	end

	// State outputs
	always_comb begin
		s_tready  = 1'b0;
		lookup_en = 1'b0;
		update_go = 1'b0;
		case (state_q)
			rtpfrt_pkg::ST_IDLE:   s_tready  = 1'b1;
			rtpfrt_pkg::ST_LOOKUP: lookup_en = 1'b1;
			rtpfrt_pkg::ST_UPDATE: update_go = !m_tvalid_q || m_tready;
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtpfrt_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Clamp oversized payloads
	always_comb begin
		if (32'(s_tdata[58:48]) > rtpfrt_pkg::MAX_FRAGMENT_BYTES) begin
			len_clamped = LEN_W'(rtpfrt_pkg::MAX_FRAGMENT_BYTES);
		end else begin
			len_clamped = s_tdata[58:48];
		end
	end

	// Capture the header word
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ts_s1   <= s_tdata[31:0];
			seq_s1  <= s_tdata[47:32];
			mark_s1 <= s_tuser;
			len_s1  <= len_clamped;
		end
	end

	// Match timestamp against all tags; lowest slot wins
	always_comb begin
		hit      = 1'b0;
		free     = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (slot_valid_q[i] && (slot_ts_q[i] == ts_s1)) begin
				hit     = 1'b1;
				hit_idx = SLOT_W'(i);
			end
			if (!slot_valid_q[i]) begin
				free     = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	// Register the match; a disabled mode never hits the table
	always_ff @(posedge clk) begin
		if (lookup_en) begin
			hit_s2      <= mode_q && hit;
			free_s2     <= free;
			hit_idx_s2  <= hit_idx;
			free_idx_s2 <= free_idx;
		end
	end

	// Slot memory read, registered
	always_ff @(posedge clk) begin
		if (lookup_en) begin
			slot_rd_q <= slot_mem[hit_idx];
		end
	end

	// Advance the matched slot record
	always_comb begin
		cnt_inc    = (slot_rd_q.count < rtpfrt_pkg::COUNT_MAX) ?
			slot_rd_q.count + CNT_W'(1) : slot_rd_q.count;
		bytes_sum  = {1'b0, slot_rd_q.bytes} + (BYTES_W + 1)'(len_s1);
		bytes_new  = (bytes_sum > {1'b0, rtpfrt_pkg::BYTES_MAX}) ?
			rtpfrt_pkg::BYTES_MAX : bytes_sum[BYTES_W-1:0];
		end_new    = mark_s1 ? seq_s1 : slot_rd_q.end_seq;
		known_new  = mark_s1 || slot_rd_q.end_known;
		expect_cnt = {1'b0, (end_new - slot_rd_q.start_seq) & rtpfrt_pkg::SEQ_MASK} +
			CNT_W'(1);
		complete   = known_new && (expect_cnt == cnt_inc);
	end

	// Decide the disposition and the record to write back
	always_comb begin
		disp_n      = rtpfrt_pkg::DISP_PASS;
		idx_n       = free_idx_s2;
		mem_we      = 1'b0;
		out_seq_n   = seq_s1;
		out_cnt_n   = CNT_W'(1);
		out_bytes_n = BYTES_W'(len_s1);
		entry_n.start_seq = slot_rd_q.start_seq;
		entry_n.end_seq   = end_new;
		entry_n.end_known = known_new;
		entry_n.count     = cnt_inc;
		entry_n.bytes     = bytes_new;
		if (!mode_q) begin
			disp_n = rtpfrt_pkg::DISP_PASS;
		end else if (hit_s2) begin
			idx_n       = hit_idx_s2;
			mem_we      = 1'b1;
			disp_n      = complete ? rtpfrt_pkg::DISP_COMPLETE : rtpfrt_pkg::DISP_STORED;
			out_seq_n   = slot_rd_q.start_seq;
			out_cnt_n   = cnt_inc;
			out_bytes_n = bytes_new;
		end else if (!mark_s1) begin
			disp_n = rtpfrt_pkg::DISP_PASS;
		end else if (!free_s2) begin
			disp_n = rtpfrt_pkg::DISP_DROP;
		end else begin
			disp_n            = rtpfrt_pkg::DISP_OPEN;
			mem_we            = 1'b1;
			entry_n.start_seq = seq_s1;
			entry_n.end_seq   = '0;
			entry_n.end_known = 1'b0;
			entry_n.count     = CNT_W'(1);
			entry_n.bytes     = BYTES_W'(len_s1);
		end
	end

	// Write back the slot record
	always_ff @(posedge clk) begin
		if (update_go && mem_we) begin
			slot_mem[idx_n] <= entry_n;
		end
	end

	// Tags: set on open
	always_ff @(posedge clk) begin
		if (update_go && (disp_n == rtpfrt_pkg::DISP_OPEN)) begin
			slot_ts_q[idx_n] <= ts_s1;
		end
	end

	// Valid bits: set on open, drop on complete
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (update_go) begin
			if (disp_n == rtpfrt_pkg::DISP_OPEN) begin
				slot_valid_q[idx_n] <= 1'b1;
			end else if (disp_n == rtpfrt_pkg::DISP_COMPLETE) begin
				slot_valid_q[idx_n] <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (update_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (update_go) begin
			out_disp_q  <= disp_n;
			out_slot_q  <= (disp_n == rtpfrt_pkg::DISP_PASS ||
				disp_n == rtpfrt_pkg::DISP_DROP) ? 3'd0 : 3'(idx_n);
			out_ts_q    <= ts_s1;
			out_seq_q   <= out_seq_n;
			out_cnt_q   <= out_cnt_n;
			out_bytes_q <= out_bytes_n;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_disp_q;
	assign m_tdata  = {1'b0, out_bytes_q, out_cnt_q, out_seq_q, out_ts_q, out_slot_q};

	`include "rtp_fragment_reassembly_tracker_top_assert.svh"

	`RTP_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "header accepted while busy")
	`RTP_ASSERT_NEXT(a_open_sets_valid, update_go && (disp_n == rtpfrt_pkg::DISP_OPEN), slot_valid_q[$past(idx_n)], "opened slot not valid")
	`RTP_ASSERT_NEXT(a_complete_frees, update_go && (disp_n == rtpfrt_pkg::DISP_COMPLETE), !slot_valid_q[$past(idx_n)], "completed slot still valid")
	`RTP_ASSERT_NOW(a_mode_off_pass, update_go && !mode_q, disp_n == rtpfrt_pkg::DISP_PASS, "table used with fragment mode off")

endmodule

@@ sim/rtp_fragment_reassembly_tracker_top_tb.sv @@
// ---------------------------------------------------------------------------
// rtp_fragment_reassembly_tracker_top_tb
// Self-checking bench for the RTP fragment reassembly tracker. Header words go
// in on the slave stream and result words come out on the master stream. A
// frame-table tracker built into the scoreboard predicts one result word per
// accepted header, and every result word is compared field by field against
// the oldest prediction. Stimulus covers a short directed sweep, random
// interleaved frames with loss, duplicates and early end markers, mode
// switches over the APB port, and one long frame sent back to back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtp_fragment_reassembly_tracker_top_tb;

	import rtpfrt_pkg::*;

	localparam int unsigned RUN_LIMIT   = 250_000;
	localparam logic [2:0]  ADDR_MODE   = 3'd0;
	localparam logic [2:0]  ADDR_UNUSED = 3'd4;
	localparam int unsigned SEG_COUNT   = 8;
	localparam int unsigned SEG_ITEMS   = 220;
	localparam int unsigned SOAK_ITEMS  = 40;
	localparam int unsigned HOLD_CYCLES = 400;

	// One predicted result word
	typedef struct {
		disp_t              disposition;
		logic [2:0]         slot;
		logic [TS_W-1:0]    ts;
		logic [SEQ_W-1:0]   start_seq;
		logic [CNT_W-1:0]   count;
		logic [BYTES_W-1:0] bytes;
	} frame_result_t;

	// A frame the stimulus is still sending
	typedef struct {
		logic [TS_W-1:0]  ts;
		logic [SEQ_W-1:0] first;
		int unsigned      total;
		int unsigned      next;
		bit               end_sent;
	} stream_frame_t;

	// Frame table tracker and result checker
	class frame_scoreboard;
		bit                 mode;
		bit                 slot_valid [DEFAULT_SLOTS];
		logic [TS_W-1:0]    slot_ts    [DEFAULT_SLOTS];
		logic [SEQ_W-1:0]   slot_start [DEFAULT_SLOTS];
		logic [SEQ_W-1:0]   slot_end   [DEFAULT_SLOTS];
		bit                 slot_ended [DEFAULT_SLOTS];
		logic [CNT_W-1:0]   slot_count [DEFAULT_SLOTS];
		logic [BYTES_W-1:0] slot_bytes [DEFAULT_SLOTS];
		frame_result_t      due_results[$];
		int unsigned        mismatches;

		function new();
			mode = 1'b0;
			mismatches = 0;
			foreach (slot_valid[i])
				slot_valid[i] = 1'b0;
		endfunction

		function int unsigned pending();
			return due_results.size();
		endfunction

		// Apply one accepted header to the table and queue its result
		function void note_header(input logic [TS_W-1:0] ts, input logic [SEQ_W-1:0] seq,
				input logic mark, input logic [LEN_W-1:0] len);
			frame_result_t r;
			int hit;
			int free_slot;
			logic [LEN_W-1:0] clamped;
			logic [BYTES_W:0] sum;
			logic [CNT_W-1:0] span;
			clamped = (len > MAX_FRAGMENT_BYTES) ? LEN_W'(MAX_FRAGMENT_BYTES) : len;
			r.disposition = DISP_PASS;
			r.slot = 3'd0;
			r.ts = ts;
			r.start_seq = seq;
			r.count = CNT_W'(1);
			r.bytes = BYTES_W'(clamped);
			if (mode) begin
				hit = -1;
				free_slot = -1;
				for (int i = 0; i < DEFAULT_SLOTS; i++) begin
					if (slot_valid[i] && slot_ts[i] == ts && hit < 0)
						hit = i;
					if (!slot_valid[i] && free_slot < 0)
						free_slot = i;
				end
				if (hit >= 0) begin
					// add to an open frame, saturating both totals
					if (slot_count[hit] < COUNT_MAX)
						slot_count[hit] = slot_count[hit] + CNT_W'(1);
					sum = {1'b0, slot_bytes[hit]} + clamped;
					slot_bytes[hit] = (sum > BYTES_MAX) ? BYTES_MAX : sum[BYTES_W-1:0];
					if (mark) begin
						slot_end[hit] = seq;
						slot_ended[hit] = 1'b1;
					end
					r.disposition = DISP_STORED;
					r.slot = 3'(hit);
					r.start_seq = slot_start[hit];
					r.count = slot_count[hit];
					r.bytes = slot_bytes[hit];
					if (slot_ended[hit]) begin
						span = {1'b0, SEQ_W'(slot_end[hit] - slot_start[hit])} + CNT_W'(1);
						if (span == slot_count[hit]) begin
							slot_valid[hit] = 1'b0;
							r.disposition = DISP_COMPLETE;
						end
					end
				end else if (mark) begin
					if (free_slot < 0) begin
						r.disposition = DISP_DROP;
					end else begin
						// open the lowest free slot
						slot_valid[free_slot] = 1'b1;
						slot_ts[free_slot] = ts;
						slot_start[free_slot] = seq;
						slot_end[free_slot] = '0;
						slot_ended[free_slot] = 1'b0;
						slot_count[free_slot] = CNT_W'(1);
						slot_bytes[free_slot] = BYTES_W'(clamped);
						r.disposition = DISP_OPEN;
						r.slot = 3'(free_slot);
					end
				end
			end
			due_results.push_back(r);
		endfunction

		function void compare(input string field, input logic [31:0] expd,
				input logic [31:0] got);
			if (got !== expd) begin
				$error("%s: expected 0x%0h, got 0x%0h", field, expd, got);
				mismatches++;
			end
		endfunction

		// Compare one result word with the oldest prediction
		function void check_result(input logic [2:0] disp, input logic [2:0] slot,
				input logic [TS_W-1:0] ts, input logic [SEQ_W-1:0] start_seq,
				input logic [CNT_W-1:0] count, input logic [BYTES_W-1:0] bytes);
			frame_result_t r;
			if (due_results.size() == 0) begin
				$error("result word with no header outstanding");
				mismatches++;
				return;
			end
			r = due_results.pop_front();
			compare("disposition", 32'(r.disposition), 32'(disp));
			compare("slot_index", 32'(r.slot), 32'(slot));
			compare("frame_timestamp", r.ts, ts);
			compare("start_seq", 32'(r.start_seq), 32'(start_seq));
			compare("fragment_count", 32'(r.count), 32'(count));
			compare("total_bytes", 32'(r.bytes), 32'(bytes));
		endfunction
	endclass

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// s_tdata: timestamp[31:0], seq_number[47:32], pkt_len[58:48], zero fill
	logic [63:0] s_tdata  = '0;
	// s_tuser: marker
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// m_tdata: slot_index[2:0], frame_timestamp[34:3], start_seq[50:35],
	//          fragment_count[67:51], total_bytes[94:68], zero fill
	logic [95:0] m_tdata;
	// m_tuser: disposition
	logic [2:0]  m_tuser;

	bit          tx_idle    = 1'b1;
	bit          rx_idle    = 1'b1;
	bit          rx_blocked = 1'b0;
	bit          hold_go    = 1'b0;
	int unsigned rx_wait    = 0;
	int unsigned cycle_count = 0;

	frame_scoreboard sb = new();
	stream_frame_t   live_frames[$];

	rtp_fragment_reassembly_tracker_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("rtp_fragment_reassembly_tracker_top regression: fail");
			$finish;
		end
	end

	// Take result words, with a random stall after each one while rx_idle is set
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tuser, m_tdata[2:0], m_tdata[34:3], m_tdata[50:35],
					m_tdata[67:51], m_tdata[94:68]);
			rx_wait = rx_idle ? $urandom_range(0, 8) : 0;
		end
		if (rx_blocked || rx_wait != 0) begin
			m_tready <= 1'b0;
			if (!rx_blocked)
				rx_wait = rx_wait - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Hold off the result side for a long stretch once asked
	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_blocked <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_blocked <= 1'b0;
	end

	function automatic logic [LEN_W-1:0] draw_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return LEN_W'($urandom_range(MAX_FRAGMENT_BYTES + 1, 2047));
		if (roll < 13)
			return '0;
		if (roll < 18)
			return LEN_W'(MAX_FRAGMENT_BYTES);
		return LEN_W'($urandom_range(0, MAX_FRAGMENT_BYTES));
	endfunction

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr[2] == REG_FRAGMENT_MODE)
			sb.mode = data[0];
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one header word, after a random gap while tx_idle is set, and wait for it to be taken
	task automatic send_header(input logic [TS_W-1:0] ts, input logic [SEQ_W-1:0] seq,
			input logic mark, input logic [LEN_W-1:0] len);
		int unsigned gap;
		gap = tx_idle ? $urandom_range(0, 8) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, len, seq, ts};
		s_tuser  <= mark;
		do @(posedge clk); while (!s_tready);
		sb.note_header(ts, seq, mark, len);
	endtask

	// Drop valid and wait for every outstanding result word
	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Close every open slot with an end marker that makes its count match
	task automatic close_open_frames();
		logic [CNT_W-1:0] next_count;
		for (int i = 0; i < DEFAULT_SLOTS; i++) begin
			if (sb.slot_valid[i]) begin
				next_count = (sb.slot_count[i] < COUNT_MAX) ?
						sb.slot_count[i] + CNT_W'(1) : sb.slot_count[i];
				send_header(sb.slot_ts[i], sb.slot_start[i] + next_count[SEQ_W-1:0] - 16'd1,
						1'b1, draw_len());
			end
		end
		live_frames.delete();
	endtask

	task automatic run_directed();
		// pass through at the reset mode, marker or not
		send_header(32'h0, 16'h0, 1'b0, 11'd0);
		send_header(32'hffff_ffff, 16'hffff, 1'b1, 11'h7ff);
		pause_until_drained();
		// a write to an unmapped register leaves the mode off
		write_reg(ADDR_UNUSED, 32'hffff_ffff);
		send_header(32'h1234_5678, 16'h0001, 1'b1, 11'd1501);
		pause_until_drained();
		write_reg(ADDR_MODE, 32'hffff_ffff);
		// frame whose sequence wraps, opened with an oversized payload
		send_header(32'hffff_ffff, 16'hfffe, 1'b1, 11'h7ff);
		send_header(32'hffff_ffff, 16'hffff, 1'b0, 11'd0);
		send_header(32'hffff_ffff, 16'h0000, 1'b1, 11'd1500);
		// unknown timestamp without marker
		send_header(32'h0, 16'd100, 1'b0, 11'd10);
		// fill the table, then one opener too many
		for (int k = 0; k < DEFAULT_SLOTS; k++)
			send_header(32'(10 + k), 16'(20 * k), 1'b1, 11'(k));
		send_header(32'd99, 16'd7, 1'b1, 11'd64);
		// end marker equal to the start, then a duplicate
		send_header(32'd12, 16'd40, 1'b1, 11'd1);
		send_header(32'd12, 16'd40, 1'b0, 11'd1);
		pause_until_drained();
		// mode off keeps the table; the frame resumes afterwards
		write_reg(ADDR_MODE, 32'h0);
		send_header(32'd11, 16'd21, 1'b0, 11'd5);
		pause_until_drained();
		write_reg(ADDR_MODE, 32'h1);
		send_header(32'd11, 16'd21, 1'b1, 11'd5);
		close_open_frames();
		pause_until_drained();
	endtask

	// Interleaved frames with random content, plus stray and damaged traffic
	task automatic run_segment(input int unsigned items);
		int unsigned done;
		int unsigned roll;
		int unsigned pick;
		stream_frame_t f;
		done = 0;
		while (done < items) begin
			roll = $urandom_range(0, 99);
			if (roll < 10) begin
				send_header($urandom(), 16'($urandom()), roll < 3, draw_len());
				done++;
			end else if (live_frames.size() == 0 || (roll < 28 && live_frames.size() < 10)) begin
				f.ts = $urandom();
				f.first = 16'($urandom());
				f.total = (roll < 12) ? $urandom_range(9, 60) : $urandom_range(2, 8);
				f.next = 1;
				f.end_sent = 1'b0;
				send_header(f.ts, f.first, 1'b1, draw_len());
				live_frames.push_back(f);
				done++;
			end else begin
				pick = $urandom_range(0, live_frames.size() - 1);
				f = live_frames[pick];
				roll = $urandom_range(0, 99);
				if (roll < 8) begin
					// resend the previous fragment
					send_header(f.ts, f.first + 16'(f.next - 1), 1'b0, draw_len());
					done++;
				end else if (roll < 12) begin
					// lose a fragment
					f.next++;
				end else if (roll < 18 && !f.end_sent && f.next < f.total - 1) begin
					// end marker ahead of the middle fragments
					send_header(f.ts, f.first + 16'(f.total - 1), 1'b1, draw_len());
					f.end_sent = 1'b1;
					done++;
				end else begin
					send_header(f.ts, f.first + 16'(f.next), f.next == f.total - 1, draw_len());
					f.next++;
					done++;
				end
				if (f.end_sent && f.next == f.total - 1)
					f.next = f.total;
				if (f.next >= f.total)
					live_frames.delete(pick);
				else
					live_frames[pick] = f;
			end
		end
	endtask

	// One long frame sent back to back with no idling on either side
	task automatic run_soak();
		logic [TS_W-1:0]  ts;
		logic [SEQ_W-1:0] first;
		ts = $urandom();
		first = 16'($urandom());
		tx_idle = 1'b0;
		rx_idle <= 1'b0;
		send_header(ts, first, 1'b1, 11'd1500);
		repeat (SOAK_ITEMS)
			send_header(ts, 16'($urandom()), 1'b0,
					($urandom_range(0, 3) == 0) ? 11'h7ff : 11'd1500);
		send_header(ts, first + 16'(SOAK_ITEMS + 1), 1'b1, 11'd1500);
		pause_until_drained();
	endtask

	initial begin
		bit          seg_mode;
		logic [31:0] data;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		for (int seg = 0; seg < SEG_COUNT; seg++) begin
			seg_mode = (seg != 3);
			tx_idle = (seg % 4 == 0) || (seg % 4 == 1);
			rx_idle <= (seg % 4 == 0) || (seg % 4 == 2);
			data = $urandom();
			data[0] = seg_mode;
			write_reg(ADDR_MODE, data);
			if (seg == 2)
				hold_go <= 1'b1;
			run_segment(SEG_ITEMS);
			// leave frames open across the mode-off segment
			if (seg_mode && seg != 2)
				close_open_frames();
			pause_until_drained();
		end

		run_soak();
		repeat (12) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("rtp_fragment_reassembly_tracker_top regression: pass");
		else
			$display("rtp_fragment_reassembly_tracker_top regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/rtpfrt_pkg.sv
rtl/rtp_fragment_reassembly_tracker_top.sv
sim/rtp_fragment_reassembly_tracker_top_tb.sv
